@@ rtl/assert_macros.svh @@
// Assertion macros shared by the tracker RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFU_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lfu tracker assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LFU_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lfu tracker assertion failed");

`endif

@@ rtl/lfu_pkg.sv @@
// Shared types and constants for the LFU replacement tracker.
// Depends on nothing; used by the interfaces, controller, datapath and top level.
package lfu_pkg;

  localparam int KEY_W = 32;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_ACCESS = 2'd2,
    CMD_EVICT  = 2'd3
  } command_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef struct packed {
    logic load;
    logic lookup;
    logic scan_step;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_evict;
    logic scan_last;
    logic out_busy;
  } ctrl_sts_t;

endpackage

@@ rtl/lfu_if.sv @@
// Request and response channel interfaces of the LFU replacement tracker.
// Depends on lfu_pkg.
interface lfu_req_if;
  logic                        valid;
  logic                        ready;
  lfu_pkg::command_t           command;
  logic [lfu_pkg::KEY_W-1:0]   key;

  modport source (output valid, output command, output key, input ready);
  modport sink (input valid, input command, input key, output ready);
endinterface

interface lfu_rsp_if;
  logic                        valid;
  logic                        ready;
  lfu_pkg::status_t            status;
  logic [lfu_pkg::KEY_W-1:0]   evicted_key;

  modport source (output valid, output status, output evicted_key, input ready);
  modport sink (input valid, input status, input evicted_key, output ready);
endinterface

@@ rtl/lfu_ctrl.sv @@
// Controller of the LFU replacement tracker: sequences lookup, scan and execute.
// Depends on lfu_pkg and lfu_if.
module lfu_ctrl (
  input  logic               clk,
  input  logic               rst,
  lfu_req_if.sink            req,
  input  lfu_pkg::ctrl_sts_t sts,
  output lfu_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_SCAN,
    S_EXEC
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) state <= S_LOOKUP;
        end
        S_LOOKUP: begin
          state <= sts.is_evict ? S_SCAN : S_EXEC;
        end
        S_SCAN: begin
          if (sts.scan_last) state <= S_EXEC;
        end
        S_EXEC: begin
          if (!sts.out_busy) state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready     = (state == S_IDLE);
  assign cmd.load      = (state == S_IDLE) && req.valid;
  assign cmd.lookup    = (state == S_LOOKUP);
  assign cmd.scan_step = (state == S_SCAN);
  assign cmd.exec      = (state == S_EXEC) && !sts.out_busy;

endmodule

@@ rtl/lfu_dpath.sv @@
// Datapath of the LFU replacement tracker: entry table, key match, victim scan,
// rank and count updates and the response register. Depends on lfu_pkg and lfu_if.
`include "assert_macros.svh"

module lfu_dpath #(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16,
  parameter int KEY_BITS   = 32
) (
  input  logic               clk,
  input  logic               rst,
  lfu_req_if.sink            req,
  lfu_rsp_if.source          rsp,
  input  lfu_pkg::ctrl_cmd_t cmd,
  output lfu_pkg::ctrl_sts_t sts
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int KW = lfu_pkg::KEY_W;

  logic                  entry_valid [ENTRIES];
  logic [KEY_BITS-1:0]   entry_key   [ENTRIES];
  logic [COUNT_BITS-1:0] entry_count [ENTRIES];
  logic [IW-1:0]         entry_rank  [ENTRIES];

  lfu_pkg::command_t     cur_cmd;
  logic [KEY_BITS-1:0]   cur_key;

  logic                  tgt_hit;
  logic [IW-1:0]         tgt_idx;
  logic [IW-1:0]         tgt_rank;
  logic [COUNT_BITS-1:0] tgt_count;
  logic                  free_hit;
  logic [IW-1:0]         free_idx;
  logic [IW-1:0]         scan_idx;

  logic                  rsp_valid;
  lfu_pkg::status_t      rsp_status;
  logic [KW-1:0]         rsp_victim;

  logic [KEY_BITS+KW-1:0] key_ext;
  logic [KEY_BITS+KW-1:0] victim_ext;
  logic [KEY_BITS-1:0]    key_in;

  logic                  m_found;
  logic [IW-1:0]         m_idx;
  logic [IW-1:0]         m_rank;
  logic                  f_found;
  logic [IW-1:0]         f_idx;
  logic                  better;
  lfu_pkg::status_t      status_next;
  logic [KW-1:0]         victim_next;
  logic                  do_add;

  assign key_ext    = {{KEY_BITS{1'b0}}, req.key};
  assign key_in     = key_ext[KEY_BITS-1:0];
  assign victim_ext = {{KW{1'b0}}, entry_key[tgt_idx]};

  always_comb begin
    m_found = 1'b0;
    m_idx   = '0;
    m_rank  = '0;
    f_found = 1'b0;
    f_idx   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (entry_valid[i] && (entry_key[i] == cur_key)) begin
        if (!m_found) m_idx = IW'(i);
        m_found = 1'b1;
        m_rank  = m_rank | entry_rank[i];
      end
      if (!entry_valid[i] && !f_found) begin
        f_found = 1'b1;
        f_idx   = IW'(i);
      end
    end
  end

  always_comb begin
    better = entry_valid[scan_idx] &&
             (!tgt_hit || (entry_count[scan_idx] < tgt_count) ||
              ((entry_count[scan_idx] == tgt_count) && (entry_rank[scan_idx] > tgt_rank)));
  end

  always_comb begin
    status_next = lfu_pkg::ST_OK;
    victim_next = '0;
    unique case (cur_cmd)
      lfu_pkg::CMD_ADD: begin
        if (tgt_hit) status_next = lfu_pkg::ST_PRESENT;
        else if (!free_hit) status_next = lfu_pkg::ST_FULL;
      end
      lfu_pkg::CMD_REMOVE, lfu_pkg::CMD_ACCESS: begin
        if (!tgt_hit) status_next = lfu_pkg::ST_NOT_FOUND;
      end
      lfu_pkg::CMD_EVICT: begin
        if (!tgt_hit) status_next = lfu_pkg::ST_EMPTY;
        else victim_next = victim_ext[KW-1:0];
      end
    endcase
  end

  assign do_add = (cur_cmd == lfu_pkg::CMD_ADD) && !tgt_hit && free_hit;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_cmd <= req.command;
      cur_key <= key_in;
    end
    if (cmd.lookup) begin
      tgt_hit  <= m_found && (cur_cmd != lfu_pkg::CMD_EVICT);
      tgt_idx  <= m_idx;
      tgt_rank <= m_rank;
      free_hit <= f_found;
      free_idx <= f_idx;
      scan_idx <= '0;
    end
    if (cmd.scan_step) begin
      if (better) begin
        tgt_hit   <= 1'b1;
        tgt_idx   <= scan_idx;
        tgt_rank  <= entry_rank[scan_idx];
        tgt_count <= entry_count[scan_idx];
      end
      scan_idx <= scan_idx + IW'(1);
    end
    if (cmd.exec) begin
      rsp_status <= status_next;
      rsp_victim <= victim_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        entry_valid[i] <= 1'b0;
      end
    end else begin
      if (cmd.exec) rsp_valid <= 1'b1;
      else if (rsp.ready) rsp_valid <= 1'b0;
      if (cmd.exec) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (do_add && (IW'(i) == free_idx)) begin
            entry_valid[i] <= 1'b1;
          end else if (tgt_hit && (IW'(i) == tgt_idx) &&
                       ((cur_cmd == lfu_pkg::CMD_REMOVE) ||
                        (cur_cmd == lfu_pkg::CMD_EVICT))) begin
            entry_valid[i] <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < ENTRIES; i++) begin
        unique case (cur_cmd)
          lfu_pkg::CMD_ADD: begin
            if (do_add) begin
              if (IW'(i) == free_idx) begin
                entry_key[i]   <= cur_key;
                entry_count[i] <= COUNT_BITS'(1);
                entry_rank[i]  <= '0;
              end else if (entry_valid[i]) begin
                entry_rank[i] <= entry_rank[i] + IW'(1);
              end
            end
          end
          lfu_pkg::CMD_REMOVE, lfu_pkg::CMD_EVICT: begin
            if (tgt_hit && (IW'(i) != tgt_idx) && entry_valid[i] &&
                (entry_rank[i] > tgt_rank)) begin
              entry_rank[i] <= entry_rank[i] - IW'(1);
            end
          end
          lfu_pkg::CMD_ACCESS: begin
            if (tgt_hit) begin
              if (IW'(i) == tgt_idx) begin
                entry_rank[i] <= '0;
                if (entry_count[i] != '1) entry_count[i] <= entry_count[i] + COUNT_BITS'(1);
              end else if (entry_valid[i] && (entry_rank[i] < tgt_rank)) begin
                entry_rank[i] <= entry_rank[i] + IW'(1);
              end
            end
          end
        endcase
      end
    end
  end

  assign sts.is_evict  = (cur_cmd == lfu_pkg::CMD_EVICT);
  assign sts.scan_last = (scan_idx == IW'(ENTRIES - 1));
  assign sts.out_busy  = rsp_valid && !rsp.ready;

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.evicted_key = rsp_victim;

  `LFU_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.exec, !(rsp_valid && !rsp.ready))
  `LFU_ASSERT_NXT(a_evict_drops, clk, rst,
    cmd.exec && (cur_cmd == lfu_pkg::CMD_EVICT) && tgt_hit, !entry_valid[$past(tgt_idx)])
  `LFU_ASSERT_NXT(a_access_newest, clk, rst,
    cmd.exec && (cur_cmd == lfu_pkg::CMD_ACCESS) && tgt_hit,
    entry_valid[$past(tgt_idx)] && (entry_rank[$past(tgt_idx)] == '0))
  `LFU_ASSERT_NXT(a_add_fills, clk, rst, cmd.exec && do_add,
    entry_valid[$past(free_idx)] && (entry_count[$past(free_idx)] == COUNT_BITS'(1)))

endmodule

@@ rtl/lfu_replacement_tracker_core.sv @@
// LFU replacement tracker top level: controller and datapath. Depends on lfu_pkg and lfu_if.
// Add, remove and access pass through lookup and execute once the request is accepted,
// and a new request is taken only when the block is back in idle. Evict walks the entry
// table one entry per cycle between lookup and execute. A stalled response holds the
// block in execute. Synchronous reset empties the table and returns the controller to idle.
module lfu_replacement_tracker_core #(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16,
  parameter int KEY_BITS   = 32
) (
  input logic       clk,
  input logic       rst,
  lfu_req_if.sink   req,
  lfu_rsp_if.source rsp
);

  lfu_pkg::ctrl_cmd_t cmd;
  lfu_pkg::ctrl_sts_t sts;

  lfu_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .req (req),
    .sts (sts),
    .cmd (cmd)
  );

  lfu_dpath #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS),
    .KEY_BITS   (KEY_BITS)
  ) u_dpath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cmd (cmd),
    .sts (sts)
  );

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for lfu_replacement_tracker_core: directed and random requests,
// each response checked against a behavioural copy of the key table held in the bench.
// Depends on lfu_pkg and the lfu_req_if / lfu_rsp_if interfaces.
module testbench;

  localparam int N_ENTRIES = 16;
  // A narrow count lets the run reach saturated counts within a few hundred requests.
  localparam int CNT_W = 4;
  localparam int RANK_W = $clog2(N_ENTRIES) + 1;
  localparam int N_RANDOM = 874;
  localparam int POOL_SIZE = 24;
  localparam int CYCLE_LIMIT = 300000;
  localparam int TAIL_CYCLES = N_ENTRIES + 8;

  typedef struct {
    lfu_pkg::command_t         cmd;
    logic [lfu_pkg::KEY_W-1:0] key;
    bit                        drain_first;
  } tracker_request_t;

  typedef struct {
    lfu_pkg::status_t          status;
    logic [lfu_pkg::KEY_W-1:0] victim;
  } tracker_outcome_t;

  logic clk;
  logic rst;

  lfu_req_if req();
  lfu_rsp_if rsp();

  lfu_replacement_tracker_core #(
    .ENTRIES(N_ENTRIES),
    .COUNT_BITS(CNT_W),
    .KEY_BITS(lfu_pkg::KEY_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  tracker_request_t pending_requests[$];
  tracker_outcome_t expected_outcomes[$];

  logic                      slot_valid[N_ENTRIES];
  logic [lfu_pkg::KEY_W-1:0] slot_key[N_ENTRIES];
  logic [CNT_W-1:0]          slot_count[N_ENTRIES];
  logic [RANK_W-1:0]         slot_rank[N_ENTRIES];

  logic [lfu_pkg::KEY_W-1:0] key_pool[POOL_SIZE];

  int accepted_count;
  int checked_count;
  int mismatch_count;
  int cycle_count;
  int in_flight;
  bit taken;
  tracker_outcome_t outcome;
  tracker_outcome_t wanted;

  function automatic int find_slot(logic [lfu_pkg::KEY_W-1:0] k);
    for (int i = 0; i < N_ENTRIES; i++) begin
      if (slot_valid[i] && slot_key[i] == k) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic void drop_slot(int e);
    slot_valid[e] = 1'b0;
    for (int i = 0; i < N_ENTRIES; i++) begin
      if (slot_valid[i] && slot_rank[i] > slot_rank[e]) begin
        slot_rank[i] = slot_rank[i] - 1'b1;
      end
    end
  endfunction

  function automatic tracker_outcome_t predict_outcome(lfu_pkg::command_t cmd,
                                                       logic [lfu_pkg::KEY_W-1:0] k);
    tracker_outcome_t res;
    int e;
    res.status = lfu_pkg::ST_OK;
    res.victim = '0;
    e = -1;
    unique case (cmd)
      lfu_pkg::CMD_ADD: begin
        if (find_slot(k) >= 0) begin
          res.status = lfu_pkg::ST_PRESENT;
        end else begin
          for (int i = N_ENTRIES - 1; i >= 0; i--) begin
            if (!slot_valid[i]) e = i;
          end
          if (e < 0) begin
            res.status = lfu_pkg::ST_FULL;
          end else begin
            for (int i = 0; i < N_ENTRIES; i++) begin
              if (slot_valid[i]) slot_rank[i] = slot_rank[i] + 1'b1;
            end
            slot_valid[e] = 1'b1;
            slot_key[e] = k;
            slot_count[e] = CNT_W'(1);
            slot_rank[e] = '0;
          end
        end
      end
      lfu_pkg::CMD_REMOVE: begin
        e = find_slot(k);
        if (e < 0) res.status = lfu_pkg::ST_NOT_FOUND;
        else drop_slot(e);
      end
      lfu_pkg::CMD_ACCESS: begin
        e = find_slot(k);
        if (e < 0) begin
          res.status = lfu_pkg::ST_NOT_FOUND;
        end else begin
          if (slot_count[e] != '1) slot_count[e] = slot_count[e] + 1'b1;
          for (int i = 0; i < N_ENTRIES; i++) begin
            if (slot_valid[i] && i != e && slot_rank[i] < slot_rank[e]) begin
              slot_rank[i] = slot_rank[i] + 1'b1;
            end
          end
          slot_rank[e] = '0;
        end
      end
      lfu_pkg::CMD_EVICT: begin
        for (int i = 0; i < N_ENTRIES; i++) begin
          if (slot_valid[i] && (e < 0 || slot_count[i] < slot_count[e] ||
              (slot_count[i] == slot_count[e] && slot_rank[i] > slot_rank[e]))) begin
            e = i;
          end
        end
        if (e < 0) begin
          res.status = lfu_pkg::ST_EMPTY;
        end else begin
          res.victim = slot_key[e];
          drop_slot(e);
        end
      end
    endcase
    return res;
  endfunction

  task automatic queue_request(lfu_pkg::command_t c, logic [lfu_pkg::KEY_W-1:0] k, bit d);
    tracker_request_t item;
    item.cmd = c;
    item.key = k;
    item.drain_first = d;
    pending_requests.push_back(item);
  endtask

  task automatic note_mismatch(string what, int want_st, logic [lfu_pkg::KEY_W-1:0] want_vk);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display({"mismatch (%s) at response %0d: expected status %0d victim %h, ",
                "got status %0d victim %h"},
               what, checked_count, want_st, want_vk, rsp.status, rsp.evicted_key);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      taken = req.valid && req.ready;
      if (taken) begin
        outcome = predict_outcome(req.command, req.key);
        expected_outcomes.push_back(outcome);
        void'(pending_requests.pop_front());
        accepted_count <= accepted_count + 1;
      end
      if (!req.valid || taken) begin
        in_flight = accepted_count + (taken ? 1 : 0) - checked_count
                    - ((rsp.valid && rsp.ready) ? 1 : 0);
        if (pending_requests.size() != 0 &&
            !(pending_requests[0].drain_first && in_flight != 0) &&
            ((accepted_count >= 400 && accepted_count < 600) ||
             $urandom_range(99) >= 24)) begin
          req.valid <= 1'b1;
          req.command <= pending_requests[0].cmd;
          req.key <= pending_requests[0].key;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_outcomes.size() == 0) begin
          note_mismatch("unexpected response", 0, '0);
        end else begin
          wanted = expected_outcomes.pop_front();
          if (rsp.status !== wanted.status) begin
            note_mismatch("status", wanted.status, wanted.victim);
          end
          if (rsp.evicted_key !== wanted.victim) begin
            note_mismatch("evicted_key", wanted.status, wanted.victim);
          end
        end
        checked_count <= checked_count + 1;
      end
      rsp.ready <= (checked_count >= 400 && checked_count < 600) ||
                   $urandom_range(99) >= 24;
    end
  end

  initial begin
    int mode;
    int r;
    int hot;
    lfu_pkg::command_t c;
    logic [lfu_pkg::KEY_W-1:0] k;
    rst = 1'b1;
    req.valid = 1'b0;
    req.command = lfu_pkg::CMD_ADD;
    req.key = '0;
    rsp.ready = 1'b0;
    accepted_count = 0;
    checked_count = 0;
    mismatch_count = 0;
    cycle_count = 0;
    for (int i = 0; i < N_ENTRIES; i++) begin
      slot_valid[i] = 1'b0;
    end
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = $urandom;
    end

    queue_request(lfu_pkg::CMD_EVICT, 32'h0, 1'b0);
    queue_request(lfu_pkg::CMD_REMOVE, 32'h0, 1'b0);
    queue_request(lfu_pkg::CMD_ACCESS, 32'hFFFF_FFFF, 1'b0);
    queue_request(lfu_pkg::CMD_ADD, 32'h0, 1'b0);
    queue_request(lfu_pkg::CMD_ADD, 32'hFFFF_FFFF, 1'b0);
    queue_request(lfu_pkg::CMD_ADD, 32'h0, 1'b0);
    // Fifteen accesses take a 4-bit count past its maximum.
    for (int i = 0; i < 15; i++) begin
      queue_request(lfu_pkg::CMD_ACCESS, 32'h0, 1'b0);
    end
    queue_request(lfu_pkg::CMD_ADD, 32'h5A5A_A5A5, 1'b0);
    queue_request(lfu_pkg::CMD_EVICT, 32'hFFFF_FFFF, 1'b0);
    queue_request(lfu_pkg::CMD_REMOVE, 32'h0, 1'b0);
    queue_request(lfu_pkg::CMD_EVICT, 32'h0, 1'b0);
    queue_request(lfu_pkg::CMD_EVICT, 32'h0, 1'b0);

    for (int n = 0; n < N_RANDOM; n++) begin
      mode = (n / 60) % 4;
      r = $urandom_range(99);
      unique case (mode)
        0: c = (r < 35) ? lfu_pkg::CMD_ADD : (r < 50) ? lfu_pkg::CMD_REMOVE :
               (r < 80) ? lfu_pkg::CMD_ACCESS : lfu_pkg::CMD_EVICT;
        1: c = (r < 60) ? lfu_pkg::CMD_ADD : (r < 65) ? lfu_pkg::CMD_REMOVE :
               (r < 90) ? lfu_pkg::CMD_ACCESS : lfu_pkg::CMD_EVICT;
        2: c = (r < 20) ? lfu_pkg::CMD_ADD : (r < 25) ? lfu_pkg::CMD_REMOVE :
               (r < 85) ? lfu_pkg::CMD_ACCESS : lfu_pkg::CMD_EVICT;
        default: c = (r < 15) ? lfu_pkg::CMD_ADD : (r < 40) ? lfu_pkg::CMD_REMOVE :
                     (r < 55) ? lfu_pkg::CMD_ACCESS : lfu_pkg::CMD_EVICT;
      endcase
      hot = (mode == 2) ? 3 : POOL_SIZE - 1;
      if ($urandom_range(99) < 8) k = $urandom;
      else k = key_pool[$urandom_range(hot)];
      queue_request(c, k, (n % 150) == 0);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending_requests.size() != 0 || req.valid ||
               accepted_count != checked_count || expected_outcomes.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_outcomes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
